/* rtl/cosc_pkg.sv */
package cosc_pkg;

   localparam int unsigned SlotDepth = 3;

   localparam logic [3:0] KIND_RAW      = 4'd0;
   localparam logic [3:0] KIND_CLEAR    = 4'd1;
   localparam logic [3:0] KIND_HOME     = 4'd2;
   localparam logic [3:0] KIND_ENTRY    = 4'd3;
   localparam logic [3:0] KIND_DISPLAY  = 4'd4;
   localparam logic [3:0] KIND_SHIFT    = 4'd5;
   localparam logic [3:0] KIND_FUNCTION = 4'd6;
   localparam logic [3:0] KIND_CGRAM    = 4'd7;
   localparam logic [3:0] KIND_DDRAM    = 4'd8;
   localparam logic [3:0] KIND_DATA     = 4'd9;

   localparam logic [7:0] OP_CLEAR    = 8'h01;
   localparam logic [7:0] OP_HOME     = 8'h02;
   localparam logic [7:0] OP_ENTRY    = 8'h04;
   localparam logic [7:0] OP_DISPLAY  = 8'h08;
   localparam logic [7:0] OP_SHIFT    = 8'h10;
   localparam logic [7:0] OP_FUNCTION = 8'h20;
   localparam logic [7:0] OP_CGRAM    = 8'h40;
   localparam logic [7:0] OP_DDRAM    = 8'h80;

   localparam logic [6:0] DDRAM_ODD_ROW  = 7'h40;
   localparam logic [6:0] DDRAM_HIGH_ROW = 7'h14;
   localparam logic [4:0] ROW_LENGTH     = 5'd20;
   localparam logic [1:0] DATA_PREAMBLE  = 2'b10;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] value;
      logic       flag_a;
      logic       flag_b;
      logic       flag_c;
      logic [1:0] mode_bits;
      logic [1:0] row;
      logic [4:0] column;
      logic [2:0] glyph_index;
      logic [2:0] glyph_row;
      logic       data_last;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       end_of_transfer;
      logic       last;
   } rsp_type;

   // Up to three bytes produced by one request.
   typedef struct packed {
      logic [SlotDepth-1:0][7:0] bytes;
      logic [SlotDepth-1:0]      eot;
      logic [1:0]                count;
   } slot_type;

endpackage

/* rtl/char_oled_spi_command_formatter.sv */
// Character OLED SPI command formatter.
// The first SPI byte of a request is driven from the registered active slot.
// One SPI byte per cycle while rsp_ready is high; a request produces 1 to 3 bytes, and
//   one more request can wait in the pending slot while the active slot drains.
// Reset (synchronous, active high) closes any open data transfer, clears the carry
//   bits and empties both the pending and the active byte slots.
module char_oled_spi_command_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cosc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cosc_pkg::rsp_type rsp_data
);
   import cosc_pkg::*;

   // Transfer state, updated at request acceptance in request order.
   logic       open_ff, open_in;
   logic [1:0] carry_ff, carry_in;

   // Pending slot: holds the bytes of a request while the active slot drains.
   logic       pend_valid_ff, pend_valid_in;
   slot_type   pend_ff, pend_in;

   // Active slot: drives the response port, one byte per cycle while rsp_ready is high.
   logic       act_valid_ff, act_valid_in;
   slot_type   act_ff, act_in;
   logic [1:0] idx_ff, idx_in;

   logic       accept;
   logic       kind_ok;
   logic       act_done;
   logic       act_free;
   logic [7:0] opcode;
   logic [4:0] col_mod;
   logic [6:0] ddram_addr;
   logic [7:0] flush_byte;
   slot_type   new_slot;

   assign req_ready = !pend_valid_ff;
   assign accept    = req_valid && req_ready;

   // Column is at most 31, so one compare and subtract covers modulo 20.
   assign col_mod = (req_data.column >= ROW_LENGTH) ? 5'(req_data.column - ROW_LENGTH)
                                                    : req_data.column;
   assign ddram_addr = (req_data.row[0] ? DDRAM_ODD_ROW : 7'd0)
                     + (req_data.row[1] ? DDRAM_HIGH_ROW : 7'd0)
                     + {2'd0, col_mod};

   assign flush_byte = {carry_ff, 6'd0};

   always_comb begin
      kind_ok = 1'b1;
      opcode  = 8'd0;
      case (req_data.kind)
         KIND_RAW:      opcode = req_data.value;
         KIND_CLEAR:    opcode = OP_CLEAR;
         KIND_HOME:     opcode = OP_HOME;
         KIND_ENTRY:    opcode = OP_ENTRY | {6'd0, req_data.flag_a, req_data.flag_b};
         KIND_DISPLAY:  opcode = OP_DISPLAY
                               | {5'd0, req_data.flag_a, req_data.flag_b, req_data.flag_c};
         KIND_SHIFT:    opcode = OP_SHIFT | {4'd0, req_data.mode_bits, 2'd0};
         KIND_FUNCTION: opcode = OP_FUNCTION | {3'd0, req_data.flag_a, 2'd0, req_data.mode_bits};
         KIND_CGRAM:    opcode = OP_CGRAM | {2'd0, req_data.glyph_index, req_data.glyph_row};
         KIND_DDRAM:    opcode = OP_DDRAM | {1'b0, ddram_addr};
         KIND_DATA:     opcode = 8'd0;
         default:       kind_ok = 1'b0;
      endcase
   end

   // Bytes for the incoming request and the transfer state it leaves behind.
   always_comb begin
      new_slot = '0;
      open_in  = open_ff;
      carry_in = carry_ff;
      if (req_data.kind == KIND_DATA) begin
         // First byte of a transfer carries the write preamble in its top bits.
         new_slot.bytes[0] = {(open_ff ? carry_ff : DATA_PREAMBLE), req_data.value[7:2]};
         new_slot.eot[0]   = 1'b0;
         if (req_data.data_last) begin
            new_slot.bytes[1] = {req_data.value[1:0], 6'd0};
            new_slot.eot[1]   = 1'b1;
            new_slot.count    = 2'd2;
            open_in           = 1'b0;
            carry_in          = 2'd0;
         end else begin
            new_slot.count    = 2'd1;
            open_in           = 1'b1;
            carry_in          = req_data.value[1:0];
         end
      end else if (kind_ok) begin
         open_in  = 1'b0;
         carry_in = 2'd0;
         if (open_ff) begin
            // Command inside an open transfer: flush the carry first.
            new_slot.bytes[0] = flush_byte;
            new_slot.eot[0]   = 1'b1;
            new_slot.bytes[1] = {2'd0, opcode[7:2]};
            new_slot.eot[1]   = 1'b0;
            new_slot.bytes[2] = {opcode[1:0], 6'd0};
            new_slot.eot[2]   = 1'b1;
            new_slot.count    = 2'd3;
         end else begin
            new_slot.bytes[0] = {2'd0, opcode[7:2]};
            new_slot.eot[0]   = 1'b0;
            new_slot.bytes[1] = {opcode[1:0], 6'd0};
            new_slot.eot[1]   = 1'b1;
            new_slot.count    = 2'd2;
         end
      end
   end

   assign act_done = act_valid_ff && rsp_ready && (idx_ff == 2'(act_ff.count - 2'd1));
   assign act_free = !act_valid_ff || act_done;

   // Slot movement: pending goes first; a new request skips the pending slot
   // when the active slot is free and nothing is pending.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      act_valid_in  = act_valid_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      if (act_valid_ff && rsp_ready && !act_done) begin
         idx_in = 2'(idx_ff + 2'd1);
      end
      if (act_free) begin
         act_valid_in = 1'b0;
         if (pend_valid_ff) begin
            act_in        = pend_ff;
            act_valid_in  = 1'b1;
            idx_in        = 2'd0;
            pend_valid_in = 1'b0;
         end else if (accept && kind_ok) begin
            act_in       = new_slot;
            act_valid_in = 1'b1;
            idx_in       = 2'd0;
         end
      end
      if (accept && kind_ok && !(act_free && !pend_valid_ff)) begin
         pend_in       = new_slot;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         carry_ff      <= 2'd0;
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         if (accept) begin
            open_ff  <= open_in;
            carry_ff <= carry_in;
         end
         pend_valid_ff <= pend_valid_in;
         act_valid_ff  <= act_valid_in;
         idx_ff        <= idx_in;
      end
      pend_ff <= pend_in;
      act_ff  <= act_in;
   end

   assign rsp_valid                = act_valid_ff;
   assign rsp_data.spi_byte        = act_ff.bytes[idx_ff];
   assign rsp_data.end_of_transfer = act_ff.eot[idx_ff];
   assign rsp_data.last            = (idx_ff == 2'(act_ff.count - 2'd1));

endmodule
